FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/pidservo_pkg.sv
// ---------------------------------------------------------------------------
// pidservo_pkg
// Widths, reset values and register indexes of the two-axis PID servo block.
// ---------------------------------------------------------------------------
package pidservo_pkg;

  localparam int AXES       = 2;
  localparam int AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int POS_W      = 12;
  localparam int ERR_W      = POS_W + 1;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int PULSE_W    = 12;
  localparam int TRIM_W     = 8;
  localparam int Q_SHIFT    = 12;

  localparam int P_W        = GAIN_W + 1 + ERR_W;
  localparam int I_W        = GAIN_W + 1 + SUM_W;
  localparam int D_W        = GAIN_W + 1 + DERIV_W;
  localparam int ACC_W      = I_W + 2;
  localparam int SHR_W      = ACC_W - Q_SHIFT;
  localparam int WID_W      = SHR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam logic [GAIN_W-1:0]  KP_RESET     = GAIN_W'(778);
  localparam logic [GAIN_W-1:0]  KI_RESET     = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  KD_RESET     = GAIN_W'(5939);
  localparam logic [PULSE_W-1:0] CENTRE_RESET = PULSE_W'(1500);
  localparam logic [PULSE_W-1:0] WMAX_RESET   = PULSE_W'(2100);
  localparam logic [PULSE_W-1:0] WMIN_RESET   = PULSE_W'(900);
  localparam logic [TRIM_W-1:0]  TRIM_RESET   = TRIM_W'(150);
  localparam logic [PULSE_W-1:0] PULSE_LIMIT  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI_DT  = 3'd1,
    REG_KD     = 3'd2,
    REG_CENTRE = 3'd3,
    REG_WMAX   = 3'd4,
    REG_WMIN   = 3'd5,
    REG_TRIM   = 3'd6
  } cfg_reg_t;

endpackage

FILE: hw/rtl/two_axis_pid_servo_duty_top.sv
// An accepted item passes through the s1, s2 and output registers before its result is presented.
// Throughput: one item per cycle unless out_tready stalls the output; the per-axis
// integral and previous error are read and written in the input stage, so items for
// one axis may follow back to back. The s2 products register follows the multipliers.
// Reset (rst_n low at a clock edge) empties the pipeline, zeroes the per-axis
// state and loads the default gains and limits.
// ---------------------------------------------------------------------------
// two_axis_pid_servo_duty_top
// Per-axis PID update with output clamp and axis 1 trim, three register stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module two_axis_pid_servo_duty_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [pidservo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidservo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // target_pos [11:0], measured_pos [23:12]
  input  logic [pidservo_pkg::IN_DATA_W-1:0]    in_tdata,
  // axis [0]
  input  logic [pidservo_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pulse_us [11:0], zero fill [15:12]
  output logic [pidservo_pkg::OUT_DATA_W-1:0]   out_tdata,
  // axis_out [0], was_clamped [1]
  output logic [pidservo_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam int POS_W   = pidservo_pkg::POS_W;
  localparam int ERR_W   = pidservo_pkg::ERR_W;
  localparam int DERIV_W = pidservo_pkg::DERIV_W;
  localparam int SUM_W   = pidservo_pkg::SUM_W;
  localparam int GAIN_W  = pidservo_pkg::GAIN_W;
  localparam int PULSE_W = pidservo_pkg::PULSE_W;
  localparam int TRIM_W  = pidservo_pkg::TRIM_W;
  localparam int P_W     = pidservo_pkg::P_W;
  localparam int I_W     = pidservo_pkg::I_W;
  localparam int D_W     = pidservo_pkg::D_W;
  localparam int ACC_W   = pidservo_pkg::ACC_W;
  localparam int SHR_W   = pidservo_pkg::SHR_W;
  localparam int WID_W   = pidservo_pkg::WID_W;
  localparam int AXES    = pidservo_pkg::AXES;
  localparam int IDX_W   = pidservo_pkg::AXIS_IDX_W;

  // Configuration registers.
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [PULSE_W-1:0] centre_r, wmax_r, wmin_r;
  logic [TRIM_W-1:0]  trim_r;

  // Per-axis state.
  logic signed [ERR_W-1:0] last_err_r [AXES];
  logic signed [SUM_W-1:0] err_sum_r  [AXES];

  // Pipeline registers.
  logic                s1_valid_r, s2_valid_r, out_valid_r;
  logic                s1_axis_r, s2_axis_r, out_axis_r;
  logic [POS_W-1:0]    s1_target_r, s1_meas_r;
  logic signed [P_W-1:0] s2_p_r;
  logic signed [I_W-1:0] s2_i_r;
  logic signed [D_W-1:0] s2_d_r;
  logic [PULSE_W-1:0]  out_pulse_r;
  logic                out_clamped_r;

  // Handshake.
  logic out_ready, s2_ready, s1_ready, s1_fire, s2_adv;

  assign out_ready = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign s2_adv    = s2_valid_r && out_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= pidservo_pkg::KP_RESET;
      ki_r     <= pidservo_pkg::KI_RESET;
      kd_r     <= pidservo_pkg::KD_RESET;
      centre_r <= pidservo_pkg::CENTRE_RESET;
      wmax_r   <= pidservo_pkg::WMAX_RESET;
      wmin_r   <= pidservo_pkg::WMIN_RESET;
      trim_r   <= pidservo_pkg::TRIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (pidservo_pkg::cfg_reg_t'(cfg_index))
        pidservo_pkg::REG_KP:     kp_r     <= cfg_wdata[GAIN_W-1:0];
        pidservo_pkg::REG_KI_DT:  ki_r     <= cfg_wdata[GAIN_W-1:0];
        pidservo_pkg::REG_KD:     kd_r     <= cfg_wdata[GAIN_W-1:0];
        pidservo_pkg::REG_CENTRE: centre_r <= cfg_wdata[PULSE_W-1:0];
        pidservo_pkg::REG_WMAX:   wmax_r   <= cfg_wdata[PULSE_W-1:0];
        pidservo_pkg::REG_WMIN:   wmin_r   <= cfg_wdata[PULSE_W-1:0];
        pidservo_pkg::REG_TRIM:   trim_r   <= cfg_wdata[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: error, integral, derivative and the three products.
  logic [IDX_W-1:0]          idx;
  logic signed [ERR_W-1:0]   err_s;
  logic signed [ERR_W-1:0]   last_s;
  logic signed [DERIV_W-1:0] deriv_s;
  logic signed [SUM_W-1:0]   sum_old;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [P_W-1:0]     prod_p;
  logic signed [I_W-1:0]     prod_i;
  logic signed [D_W-1:0]     prod_d;

  always_comb begin
    idx      = (32'(s1_axis_r) < AXES) ? IDX_W'(s1_axis_r) : IDX_W'(AXES - 1);
    err_s    = $signed({1'b0, s1_target_r}) - $signed({1'b0, s1_meas_r});
    last_s   = last_err_r[idx];
    deriv_s  = $signed({err_s[ERR_W-1], err_s}) - $signed({last_s[ERR_W-1], last_s});
    sum_old  = err_sum_r[idx];
    sum_wide = $signed({sum_old[SUM_W-1], sum_old})
             + $signed({{(SUM_W + 1 - ERR_W){err_s[ERR_W-1]}}, err_s});
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    prod_p = $signed({1'b0, kp_r}) * err_s;
    prod_i = $signed({1'b0, ki_r}) * sum_sat;
    prod_d = $signed({1'b0, kd_r}) * deriv_s;
  end

  // Stage 2: sum, scale, centre, clamp and trim.
  logic signed [ACC_W-1:0] acc_s;
  logic signed [WID_W-1:0] width_s;
  logic [PULSE_W-1:0]      clamp_w;
  logic                    clamp_hit;
  logic [PULSE_W:0]        trim_sum;
  logic [PULSE_W-1:0]      pulse_nxt;

  always_comb begin
    acc_s   = $signed({{(ACC_W - P_W){s2_p_r[P_W-1]}}, s2_p_r})
            + $signed({{(ACC_W - I_W){s2_i_r[I_W-1]}}, s2_i_r})
            + $signed({{(ACC_W - D_W){s2_d_r[D_W-1]}}, s2_d_r});
    width_s = $signed({acc_s[ACC_W-1], acc_s[ACC_W-1:ACC_W-SHR_W]})
            + $signed({{(WID_W - PULSE_W){1'b0}}, centre_r});
    priority if (width_s > $signed({{(WID_W - PULSE_W){1'b0}}, wmax_r})) begin
      clamp_w   = wmax_r;
      clamp_hit = 1'b1;
    end else if (width_s < $signed({{(WID_W - PULSE_W){1'b0}}, wmin_r})) begin
      clamp_w   = wmin_r;
      clamp_hit = 1'b1;
    end else begin
      clamp_w   = width_s[PULSE_W-1:0];
      clamp_hit = 1'b0;
    end
    trim_sum = {1'b0, clamp_w} + {{(PULSE_W + 1 - TRIM_W){1'b0}}, trim_r};
    if (!s2_axis_r) begin
      pulse_nxt = clamp_w;
    end else if (trim_sum[PULSE_W]) begin
      pulse_nxt = pidservo_pkg::PULSE_LIMIT;
    end else begin
      pulse_nxt = trim_sum[PULSE_W-1:0];
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < AXES; k++) begin
        last_err_r[k] <= '0;
        err_sum_r[k]  <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s2_valid_r;
      end
      if (s1_fire) begin
        last_err_r[idx] <= err_s;
        err_sum_r[idx]  <= sum_sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_axis_r   <= in_tuser[0];
      s1_target_r <= in_tdata[POS_W-1:0];
      s1_meas_r   <= in_tdata[2*POS_W-1:POS_W];
    end
    if (s1_fire) begin
      s2_axis_r <= s1_axis_r;
      s2_p_r    <= prod_p;
      s2_i_r    <= prod_i;
      s2_d_r    <= prod_d;
    end
    if (s2_adv) begin
      out_axis_r    <= s2_axis_r;
      out_pulse_r   <= pulse_nxt;
      out_clamped_r <= clamp_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pidservo_pkg::OUT_DATA_W - PULSE_W){1'b0}}, out_pulse_r};
  assign out_tuser  = {out_clamped_r, out_axis_r};

  `ASSERT_IMPL(a_ready_when_empty, !s1_valid_r, in_tready)
  `ASSERT_IMPL(a_sum_direction, s1_fire, (err_s >= 0) ? (sum_sat >= sum_old) : (sum_sat <= sum_old))
  `ASSERT_NEXT(a_s2_holds_on_stall, s2_valid_r && !out_ready, s2_valid_r)

endmodule
